FILE: sv/cwd_pkg.sv
// Shared types, constants and the CRC-8 step function for the CRC-checked word deframer.
// Used by every module of the block; it depends on nothing else.
package cwd_pkg;

  // Default for the largest number of words in one frame.
  localparam int MAX_WORDS_DEF = 8;

  // CRC-8 settings: polynomial x^8 + x^5 + x^4 + 1, no reflection, no final XOR.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Words that hold these values carry no valid reading.
  localparam logic [15:0] SENTINEL_UNSIGNED = 16'hFFFF;
  localparam logic [15:0] SENTINEL_SIGNED   = 16'h7FFF;

  // Configuration port.
  localparam int CFG_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_WORDS = 1'b1;
  localparam logic [CFG_W-1:0] WORD_COUNT_RESET     = 4'd8;
  localparam logic [CFG_W-1:0] UNSIGNED_WORDS_RESET = 4'd4;

  // Queue between the byte front end and the result back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Position of a byte within its triple, one-hot.
  typedef enum logic [2:0] {
    PHASE_MSB = 3'b001,
    PHASE_LSB = 3'b010,
    PHASE_CRC = 3'b100
  } byte_phase_t;

  // One received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic [15:0] word_value;
    logic [2:0]  word_index;
    logic        crc_ok;
    logic        unknown_value;
    logic        last_word;
  } out_item_t;

  // A completed triple as the front end classifies it.
  typedef struct packed {
    logic [15:0] word_value;
    logic [2:0]  word_index;
    logic        crc_ok;
    logic        last_word;
    logic        use_unsigned;
  } word_rec_t;

  // Advance the CRC by one byte, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/cwd_front.sv
// Front end of the deframer: takes bytes, tracks the triple phase, the CRC and the frame.
// On each CRC byte of an open frame it pushes one classified word record. Depends on cwd_pkg.
module cwd_front #(
  parameter int MAX_WORDS = cwd_pkg::MAX_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  cwd_pkg::in_item_t          item,
  input  logic [cwd_pkg::CFG_W-1:0]  word_count,
  input  logic [cwd_pkg::CFG_W-1:0]  unsigned_words,
  output logic                       push,
  output cwd_pkg::word_rec_t         push_rec
);

  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int CMP_W = ((CNT_W > cwd_pkg::CFG_W) ? CNT_W : cwd_pkg::CFG_W) + 1;

  cwd_pkg::byte_phase_t phase, phase_next;
  logic [7:0]           crc, crc_next;
  logic [7:0]           held_msb, held_lsb;
  logic [CNT_W-1:0]     words_done, words_done_next;
  logic                 closed, closed_next;

  cwd_pkg::byte_phase_t cur_phase;
  logic [7:0]           cur_crc;
  logic [CNT_W-1:0]     cur_done;
  logic                 live;
  logic [CMP_W-1:0]     eff_count;
  logic [CMP_W-1:0]     done_plus;
  logic                 crc_match;
  logic                 is_last;

  // A frame start restarts the triple, the CRC and the word count.
  assign live      = accept && (item.frame_start || !closed);
  assign cur_phase = item.frame_start ? cwd_pkg::PHASE_MSB : phase;
  assign cur_crc   = item.frame_start ? cwd_pkg::CRC_INIT : crc;
  assign cur_done  = item.frame_start ? '0 : words_done;

  // Clamp the configured count into one to MAX_WORDS.
  always_comb begin
    if (word_count == '0) begin
      eff_count = CMP_W'(1);
    end else if (CMP_W'(word_count) > CMP_W'(MAX_WORDS)) begin
      eff_count = CMP_W'(MAX_WORDS);
    end else begin
      eff_count = CMP_W'(word_count);
    end
  end

  assign done_plus = CMP_W'(cur_done) + CMP_W'(1);
  assign crc_match = (cur_crc == item.rx_byte);
  assign is_last   = !crc_match || (done_plus >= eff_count);

  // Word record pushed on the CRC byte.
  assign push                  = live && (cur_phase == cwd_pkg::PHASE_CRC);
  assign push_rec.word_value   = {held_msb, held_lsb};
  assign push_rec.word_index   = 3'(cur_done);
  assign push_rec.crc_ok       = crc_match;
  assign push_rec.last_word    = is_last;
  assign push_rec.use_unsigned = CMP_W'(cur_done) < CMP_W'(unsigned_words);

  // Next state of the triple tracker.
  always_comb begin
    phase_next      = phase;
    crc_next        = crc;
    words_done_next = words_done;
    closed_next     = closed;
    if (live) begin
      words_done_next = cur_done;
      closed_next     = 1'b0;
      unique case (cur_phase)
        cwd_pkg::PHASE_MSB: begin
          crc_next   = cwd_pkg::crc8_update(cur_crc, item.rx_byte);
          phase_next = cwd_pkg::PHASE_LSB;
        end
        cwd_pkg::PHASE_LSB: begin
          crc_next   = cwd_pkg::crc8_update(cur_crc, item.rx_byte);
          phase_next = cwd_pkg::PHASE_CRC;
        end
        cwd_pkg::PHASE_CRC: begin
          crc_next        = cwd_pkg::CRC_INIT;
          phase_next      = cwd_pkg::PHASE_MSB;
          words_done_next = CNT_W'(done_plus);
          closed_next     = is_last;
        end
        default: begin
          phase_next = cwd_pkg::PHASE_MSB;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cwd_pkg::PHASE_MSB;
      crc        <= cwd_pkg::CRC_INIT;
      words_done <= '0;
      closed     <= 1'b1;
    end else begin
      phase      <= phase_next;
      crc        <= crc_next;
      words_done <= words_done_next;
      closed     <= closed_next;
    end
  end

  // Held data bytes of the current triple.
  always_ff @(posedge clk) begin
    if (live && (cur_phase == cwd_pkg::PHASE_MSB)) begin
      held_msb <= item.rx_byte;
    end
    if (live && (cur_phase == cwd_pkg::PHASE_LSB)) begin
      held_lsb <= item.rx_byte;
    end
  end

endmodule

FILE: sv/cwd_queue.sv
// Short first-in first-out queue of word records between the front and back ends.
// Depends on cwd_pkg for the record type and the depth.
module cwd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cwd_pkg::word_rec_t push_rec,
  input  logic               pop,
  output cwd_pkg::word_rec_t head_rec,
  output logic               empty,
  output logic               full
);

  cwd_pkg::word_rec_t                 entries [cwd_pkg::QUEUE_DEPTH];
  logic [cwd_pkg::QPTR_W-1:0]         wr_ptr, rd_ptr;
  logic [cwd_pkg::QCNT_W-1:0]         count;

  assign empty    = (count == '0);
  assign full     = (count == cwd_pkg::QCNT_W'(cwd_pkg::QUEUE_DEPTH));
  assign head_rec = entries[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers wrap over the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cwd_pkg::QPTR_W'(cwd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr + cwd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cwd_pkg::QPTR_W'(cwd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr + cwd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + cwd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - cwd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/cwd_back.sv
// Back end of the deframer: checks each word against its sentinel and holds the result
// in the output register until the receiver takes it. Depends on cwd_pkg.
module cwd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  cwd_pkg::word_rec_t        head_rec,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cwd_pkg::out_item_t        out_item
);

  logic [15:0]        sentinel;
  cwd_pkg::out_item_t result;

  // Take the next record whenever the output register is free or being drained.
  assign pop = !q_empty && (!out_valid || out_ready);

  // Sentinel comparison.
  assign sentinel = head_rec.use_unsigned ? cwd_pkg::SENTINEL_UNSIGNED
                                          : cwd_pkg::SENTINEL_SIGNED;

  always_comb begin
    result.word_value    = head_rec.word_value;
    result.word_index    = head_rec.word_index;
    result.crc_ok        = head_rec.crc_ok;
    result.unknown_value = (head_rec.word_value == sentinel);
    result.last_word     = head_rec.last_word;
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= result;
    end
  end

endmodule

FILE: sv/crc_checked_word_deframer.sv
// Top level of the CRC-checked word deframer: configuration registers and the three stages.
// Depends on cwd_pkg, cwd_front, cwd_queue and cwd_back.
//
// Usage:
//   Bytes of a sensor response enter on in_valid/in_ready/in_item, one per transfer.
//   A byte with frame_start set opens a frame and is its first MSB. Each MSB, LSB and
//   CRC triple produces one word on out_valid/out_ready/out_item with its index, a
//   CRC-ok bit, an unknown-value bit and a last-word bit. The last word or a CRC error
//   closes the frame; later bytes are dropped until the next frame start.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 is word_count,
//   1 is unsigned_words); write only while no result is outstanding.
//   Throughput: one byte per cycle while in_ready is high. After the transfer of its
//   CRC byte, a result is classified by the front end in the cycle of the transfer,
//   then written into the two-entry record queue and from there into the output register.
//   When the receiver stalls, the queue fills and in_ready drops once it holds two
//   records; bytes that produce no result are held back at that point as well.
//   Reset (synchronous) empties the queue and output register, closes the frame and
//   loads word_count = 8 and unsigned_words = 4.
module crc_checked_word_deframer #(
  parameter int MAX_WORDS = cwd_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cwd_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cwd_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [cwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwd_pkg::CFG_W-1:0]      cfg_data
);

  logic [cwd_pkg::CFG_W-1:0] word_count;
  logic [cwd_pkg::CFG_W-1:0] unsigned_words;
  logic                      in_accept;
  logic                      push, pop;
  logic                      q_empty, q_full;
  cwd_pkg::word_rec_t        push_rec, head_rec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count     <= cwd_pkg::WORD_COUNT_RESET;
      unsigned_words <= cwd_pkg::UNSIGNED_WORDS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwd_pkg::REG_WORD_COUNT:     word_count     <= cfg_data;
        cwd_pkg::REG_UNSIGNED_WORDS: unsigned_words <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  cwd_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .item          (in_item),
    .word_count    (word_count),
    .unsigned_words(unsigned_words),
    .push          (push),
    .push_rec      (push_rec)
  );

  cwd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head_rec(head_rec),
    .empty   (q_empty),
    .full    (q_full)
  );

  cwd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head_rec (head_rec),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

FILE: sv/cwd_checker.sv
// Port-level checks for the CRC-checked word deframer, bound to the top level.
// Depends on cwd_pkg and crc_checked_word_deframer.
module cwd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cwd_pkg::out_item_t out_item
);

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result pending and the input open.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A CRC error always ends the frame.
  a_crc_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.crc_ok |-> out_item.last_word)
    else $error("CRC error without last word");

  // Unknown is flagged only on a sentinel value.
  a_unknown_sentinel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.unknown_value |->
      out_item.word_value == cwd_pkg::SENTINEL_UNSIGNED ||
      out_item.word_value == cwd_pkg::SENTINEL_SIGNED)
    else $error("unknown flag on a non-sentinel word");

endmodule

bind crc_checked_word_deframer cwd_checker u_cwd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
